// ===== rtl/wcg_pkg.sv =====
// Shared types and constants of the window coefficient generator.
package wcg_pkg;

    // Register word selected by paddr[2].
    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_SHAPE  = 1'b1;

    // Shape codes held in the shape register.
    localparam logic [2:0] SHAPE_HANN      = 3'd0;
    localparam logic [2:0] SHAPE_HALF_ROOT = 3'd1;
    localparam logic [2:0] SHAPE_ROOT      = 3'd2;
    localparam logic [2:0] SHAPE_QUAD_ROOT = 3'd3;
    localparam logic [2:0] SHAPE_TRI       = 3'd4;

    localparam logic [12:0] LENGTH_RESET = 13'd1024;

    // Pi in Q30.
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    // Taylor series divisors and their reciprocals floor(2^34 / k).
    localparam logic [6:0]  SIN_DIV   [5] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] SIN_RECIP [5] = '{32'd156180628, 32'd238609294,
                                              32'd409044504, 32'd858993459,
                                              32'd2863311530};

    localparam int DIV_STAGES  = 45;
    localparam int SINE_STAGES = 19;
    localparam int SQRT_STAGES = 31;

    // Control information that travels with every transaction.
    typedef struct packed {
        logic        oor;
        logic [2:0]  shape;
        logic        peak;
        logic        tri_sat;
        logic [31:0] tri_val;
    } ctl_t;

endpackage

// ===== rtl/wcg_divider.sv =====
// Pipelined restoring divider computing floor(num * 2^32 / den), one quotient bit per stage.
module wcg_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  wcg_pkg::ctl_t     in_ctl,
    input  logic [12:0]       in_num,
    input  logic [12:0]       in_den,
    output logic              out_valid,
    output wcg_pkg::ctl_t     out_ctl,
    output logic [33:0]       out_quot
);

    localparam int N = wcg_pkg::DIV_STAGES;

    logic          vld_reg  [0:N-1];
    wcg_pkg::ctl_t ctl_reg  [0:N-1];
    logic [12:0]   num_reg  [0:N-1];
    logic [12:0]   den_reg  [0:N-1];
    logic [12:0]   rem_reg  [0:N-1];
    logic [33:0]   quot_reg [0:N-1];

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_stage
            logic          src_vld;
            wcg_pkg::ctl_t src_ctl;
            logic [12:0]   src_num;
            logic [12:0]   src_den;
            logic [12:0]   src_rem;
            logic [33:0]   src_quot;
            logic [13:0]   shifted;
            logic          ge;
            logic [12:0]   rem_next;
            logic [33:0]   quot_next;

            if (j == 0)
            begin : g_first
                assign src_vld  = in_valid;
                assign src_ctl  = in_ctl;
                assign src_num  = in_num;
                assign src_den  = in_den;
                assign src_rem  = '0;
                assign src_quot = '0;
            end
            else
            begin : g_next
                assign src_vld  = vld_reg[j-1];
                assign src_ctl  = ctl_reg[j-1];
                assign src_num  = num_reg[j-1];
                assign src_den  = den_reg[j-1];
                assign src_rem  = rem_reg[j-1];
                assign src_quot = quot_reg[j-1];
            end

            always_comb
            begin
                shifted   = {src_rem, src_num[12]};
                ge        = shifted >= {1'b0, src_den};
                rem_next  = ge ? 13'(shifted - {1'b0, src_den}) : shifted[12:0];
                quot_next = {src_quot[32:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else
                    vld_reg[j] <= src_vld;
            end

            always_ff @(posedge clk)
            begin
                ctl_reg[j]  <= src_ctl;
                num_reg[j]  <= {src_num[11:0], 1'b0};
                den_reg[j]  <= src_den;
                rem_reg[j]  <= rem_next;
                quot_reg[j] <= quot_next;
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
    assign out_quot  = quot_reg[N-1];

endmodule

// ===== rtl/wcg_sine.sv =====
// Pipelined Q30 sine of a folded phase followed by squaring into the Hann value.
module wcg_sine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  wcg_pkg::ctl_t     in_ctl,
    input  logic [31:0]       in_q,
    output logic              out_valid,
    output wcg_pkg::ctl_t     out_ctl,
    output logic [30:0]       out_h
);

    localparam int N = wcg_pkg::SINE_STAGES;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    logic          vld_reg [0:N-1];
    wcg_pkg::ctl_t ctl_reg [0:N-1];
    logic [30:0]   t_reg   [0:N-1];
    logic [31:0]   t2_reg  [1:N-1];
    logic [31:0]   m_reg   [5];
    logic [31:0]   mb_reg  [5];
    logic [29:0]   e_reg   [5];
    logic [30:0]   r_reg   [5];
    logic [30:0]   s_reg;
    logic [30:0]   h_reg;
    logic [63:0]   t_prod;
    logic [61:0]   t2_prod;
    logic [61:0]   s_prod;
    logic [60:0]   h_prod;

    assign t_prod  = {32'b0, in_q} * {32'b0, wcg_pkg::PI_Q30};
    assign t2_prod = {31'b0, t_reg[0]} * {31'b0, t_reg[0]};
    assign s_prod  = {31'b0, t_reg[16]} * {31'b0, r_reg[4]};
    assign h_prod  = {30'b0, s_reg} * {30'b0, s_reg};

    always_ff @(posedge clk)
    begin
        ctl_reg[0] <= in_ctl;
        t_reg[0]   <= t_prod[62:32];
        t2_reg[1]  <= t2_prod[61:30];
        s_reg      <= (s_prod[61:30] > {1'b0, ONE_Q30}) ? ONE_Q30 : s_prod[60:30];
        h_reg      <= h_prod[60:30];
    end

    genvar s, k;
    generate
        for (s = 0; s < N; s++)
        begin : g_carry
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (s == 0)
                    vld_reg[s] <= in_valid;
                else
                    vld_reg[s] <= vld_reg[(s == 0) ? 0 : s-1];
            end

            if (s > 0)
            begin : g_pass
                always_ff @(posedge clk)
                begin
                    ctl_reg[s] <= ctl_reg[s-1];
                    t_reg[s]   <= t_reg[s-1];
                end
            end

            if (s > 1)
            begin : g_t2
                always_ff @(posedge clk)
                begin
                    t2_reg[s] <= t2_reg[s-1];
                end
            end
        end

        // One Horner step per term: multiply, reciprocal multiply, correct and subtract.
        for (k = 0; k < 5; k++)
        begin : g_term
            logic [30:0] r_src;
            logic [61:0] m_prod;
            logic [63:0] e_prod;
            logic [36:0] back;
            logic [36:0] rem;
            logic [30:0] quo;

            if (k == 0)
            begin : g_r0
                assign r_src = ONE_Q30;
            end
            else
            begin : g_rk
                assign r_src = r_reg[k-1];
            end

            always_comb
            begin
                m_prod = {30'b0, t2_reg[1+3*k]} * {31'b0, r_src};
                e_prod = {32'b0, m_reg[k]} * {32'b0, wcg_pkg::SIN_RECIP[k]};
                back   = {7'b0, e_reg[k]} * {30'b0, wcg_pkg::SIN_DIV[k]};
                rem    = {5'b0, mb_reg[k]} - back;
                quo    = {1'b0, e_reg[k]} + ((rem >= {30'b0, wcg_pkg::SIN_DIV[k]}) ? 31'd1 : 31'd0);
            end

            always_ff @(posedge clk)
            begin
                m_reg[k]  <= m_prod[61:30];
                e_reg[k]  <= e_prod[63:34];
                mb_reg[k] <= m_reg[k];
                r_reg[k]  <= 31'(ONE_Q30 - quo);
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
    assign out_h     = h_reg;

endmodule

// ===== rtl/wcg_sqrt.sv =====
// Pipelined integer square root of a 61-bit value, one result bit per stage.
module wcg_sqrt
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  wcg_pkg::ctl_t     in_ctl,
    input  logic [60:0]       in_x,
    input  logic [31:0]       in_side,
    output logic              out_valid,
    output wcg_pkg::ctl_t     out_ctl,
    output logic [30:0]       out_root,
    output logic [31:0]       out_side
);

    localparam int N = wcg_pkg::SQRT_STAGES;

    logic          vld_reg  [0:N-1];
    wcg_pkg::ctl_t ctl_reg  [0:N-1];
    logic [60:0]   rem_reg  [0:N-1];
    logic [30:0]   res_reg  [0:N-1];
    logic [31:0]   side_reg [0:N-1];

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_stage
            localparam int B = N - 1 - j;
            logic          src_vld;
            wcg_pkg::ctl_t src_ctl;
            logic [60:0]   src_rem;
            logic [30:0]   src_res;
            logic [31:0]   src_side;
            logic [63:0]   trial;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign src_vld  = in_valid;
                assign src_ctl  = in_ctl;
                assign src_rem  = in_x;
                assign src_res  = '0;
                assign src_side = in_side;
            end
            else
            begin : g_next
                assign src_vld  = vld_reg[j-1];
                assign src_ctl  = ctl_reg[j-1];
                assign src_rem  = rem_reg[j-1];
                assign src_res  = res_reg[j-1];
                assign src_side = side_reg[j-1];
            end

            // (res + 2^B)^2 - res^2 = res * 2^(B+1) + 2^(2B)
            always_comb
            begin
                trial = ({33'b0, src_res} << (B + 1)) + (64'd1 << (2 * B));
                ge    = {3'b0, src_rem} >= trial;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else
                    vld_reg[j] <= src_vld;
            end

            always_ff @(posedge clk)
            begin
                ctl_reg[j]  <= src_ctl;
                side_reg[j] <= src_side;
                rem_reg[j]  <= ge ? 61'({3'b0, src_rem} - trial) : src_rem;
                res_reg[j]  <= ge ? (src_res | (31'd1 << B)) : src_res;
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
    assign out_root  = res_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== rtl/window_coefficient_generator_top.sv =====
// Top level of the window coefficient generator with its register port.
//
// The block takes one sample index per clock whenever start is high (busy stays low)
// and returns one coefficient transaction for every index, strobed by done and in order.
// The receiver cannot stall, so done, coefficient and index_out_of_range must be
// captured in the cycle they appear. The pipeline runs through a 45-stage bit-serial
// divider that forms the phase i/(N-1) (or the triangle ramp), a 19-stage sine and
// square unit, and two 31-stage square root pipelines that give the root and
// fourth-root shapes. Every stage takes a new transaction each cycle.
// The window length and shape registers are written over the APB port at byte
// addresses 0 and 4 and must only change while no transaction is in flight; a length
// above MAX_LENGTH is treated as MAX_LENGTH. No clearing pass is needed after reset.
module window_coefficient_generator_top
#(
    parameter int MAX_LENGTH     = 4096,
    parameter int COEF_FRAC_BITS = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] sample_index,
    output logic        done,
    output logic [15:0] coefficient,
    output logic        index_out_of_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LATENCY = 3 + wcg_pkg::DIV_STAGES + wcg_pkg::SINE_STAGES
                             + 2 * wcg_pkg::SQRT_STAGES;
    localparam int MAX_N_INT = (MAX_LENGTH > 8191) ? 8191 : MAX_LENGTH;
    localparam logic [12:0] MAX_N = 13'(MAX_N_INT);

    // Configuration registers.
    logic [12:0] length_reg;
    logic [2:0]  shape_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= wcg_pkg::LENGTH_RESET;
            shape_reg  <= wcg_pkg::SHAPE_HANN;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                wcg_pkg::REG_LENGTH: length_reg <= pwdata[12:0];
                wcg_pkg::REG_SHAPE:  shape_reg  <= pwdata[2:0];
                default:             length_reg <= length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            wcg_pkg::REG_LENGTH: prdata = {19'b0, length_reg};
            wcg_pkg::REG_SHAPE:  prdata = {29'b0, shape_reg};
            default:             prdata = '0;
        endcase
    end

    // Entry stage: range check and divider operands.
    logic [12:0]   n_eff;
    logic [11:0]   half;
    wcg_pkg::ctl_t ent_ctl_next;
    logic [12:0]   ent_num_next;
    logic [12:0]   ent_den_next;
    logic          ent_valid_reg;
    wcg_pkg::ctl_t ent_ctl_reg;
    logic [12:0]   ent_num_reg;
    logic [12:0]   ent_den_reg;

    always_comb
    begin
        n_eff = (length_reg > MAX_N) ? MAX_N : length_reg;
        half  = n_eff[12:1];
        ent_ctl_next.oor     = {1'b0, sample_index} >= n_eff;
        ent_ctl_next.shape   = shape_reg;
        ent_ctl_next.peak    = n_eff < 13'd2;
        ent_ctl_next.tri_sat = half == 12'd0;
        ent_ctl_next.tri_val = '0;
        if (shape_reg == wcg_pkg::SHAPE_TRI)
        begin
            // Rising edge uses i, falling edge uses N - i, both over N/2.
            ent_num_next = (sample_index < half) ? {1'b0, sample_index}
                                                 : 13'(n_eff - {1'b0, sample_index});
            ent_den_next = (half == 12'd0) ? 13'd1 : {1'b0, half};
        end
        else
        begin
            ent_num_next = {1'b0, sample_index};
            ent_den_next = (n_eff < 13'd2) ? 13'd1 : 13'(n_eff - 13'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_valid_reg <= 1'b0;
        else
            ent_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        ent_ctl_reg <= ent_ctl_next;
        ent_num_reg <= ent_num_next;
        ent_den_reg <= ent_den_next;
    end

    logic          div_valid;
    wcg_pkg::ctl_t div_ctl;
    logic [33:0]   div_quot;

    wcg_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ent_valid_reg),
        .in_ctl    (ent_ctl_reg),
        .in_num    (ent_num_reg),
        .in_den    (ent_den_reg),
        .out_valid (div_valid),
        .out_ctl   (div_ctl),
        .out_quot  (div_quot)
    );

    // Fold stage: the phase is mirrored about the window center, the triangle is scaled.
    logic [32:0]   phase;
    logic [31:0]   fold_q_next;
    wcg_pkg::ctl_t fold_ctl_next;
    logic          fold_valid_reg;
    wcg_pkg::ctl_t fold_ctl_reg;
    logic [31:0]   fold_q_reg;

    always_comb
    begin
        phase = div_quot[32:0];
        if (div_ctl.peak)
            fold_q_next = 32'h8000_0000;
        else if (phase <= 33'h0_8000_0000)
            fold_q_next = phase[31:0];
        else
            fold_q_next = 32'(33'h1_0000_0000 - phase);
        fold_ctl_next         = div_ctl;
        fold_ctl_next.tri_val = div_quot[33:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else
            fold_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        fold_ctl_reg <= fold_ctl_next;
        fold_q_reg   <= fold_q_next;
    end

    logic          sin_valid;
    wcg_pkg::ctl_t sin_ctl;
    logic [30:0]   sin_h;

    wcg_sine u_sine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid_reg),
        .in_ctl    (fold_ctl_reg),
        .in_q      (fold_q_reg),
        .out_valid (sin_valid),
        .out_ctl   (sin_ctl),
        .out_h     (sin_h)
    );

    logic          sq1_valid;
    wcg_pkg::ctl_t sq1_ctl;
    logic [30:0]   sq1_root;
    logic [31:0]   sq1_side;

    wcg_sqrt u_sqrt_root
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sin_valid),
        .in_ctl    (sin_ctl),
        .in_x      ({sin_h, 30'b0}),
        .in_side   ({1'b0, sin_h}),
        .out_valid (sq1_valid),
        .out_ctl   (sq1_ctl),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );

    // The value for the Hann, half root and root shapes rides along the second root.
    logic [31:0] sq2_side_in;

    always_comb
    begin
        case (sq1_ctl.shape)
            wcg_pkg::SHAPE_HANN:      sq2_side_in = sq1_side;
            wcg_pkg::SHAPE_HALF_ROOT: sq2_side_in = {2'b0, sq1_root[30:1]};
            default:                  sq2_side_in = {1'b0, sq1_root};
        endcase
    end

    logic          sq2_valid;
    wcg_pkg::ctl_t sq2_ctl;
    logic [30:0]   sq2_root;
    logic [31:0]   sq2_side;

    wcg_sqrt u_sqrt_quad
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq1_valid),
        .in_ctl    (sq1_ctl),
        .in_x      ({sq1_root, 30'b0}),
        .in_side   (sq2_side_in),
        .out_valid (sq2_valid),
        .out_ctl   (sq2_ctl),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    // Output stage: shape select, rounding to the output format and saturation.
    logic [31:0] win_val;
    logic [32:0] conv;
    logic [15:0] coef_next;
    logic        done_reg;
    logic [15:0] coefficient_reg;
    logic        oor_reg;

    always_comb
    begin
        case (sq2_ctl.shape)
            wcg_pkg::SHAPE_HANN,
            wcg_pkg::SHAPE_HALF_ROOT,
            wcg_pkg::SHAPE_ROOT:      win_val = sq2_side;
            wcg_pkg::SHAPE_QUAD_ROOT: win_val = {1'b0, sq2_root};
            wcg_pkg::SHAPE_TRI:       win_val = sq2_ctl.tri_val;
            default:                  win_val = '0;
        endcase
    end

    generate
        if (COEF_FRAC_BITS < 30)
        begin : g_round
            localparam int SH = 30 - COEF_FRAC_BITS;
            assign conv = ({1'b0, win_val} + (33'd1 << (SH - 1))) >> SH;
        end
        else if (COEF_FRAC_BITS == 30)
        begin : g_exact
            assign conv = {1'b0, win_val};
        end
        else
        begin : g_double
            assign conv = {win_val, 1'b0};
        end
    endgenerate

    always_comb
    begin
        if (sq2_ctl.oor)
            coef_next = '0;
        else if (sq2_ctl.shape == wcg_pkg::SHAPE_TRI && sq2_ctl.tri_sat)
            coef_next = 16'hFFFF;
        else if (conv > 33'd65535)
            coef_next = 16'hFFFF;
        else
            coef_next = conv[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sq2_valid;
    end

    always_ff @(posedge clk)
    begin
        coefficient_reg <= coef_next;
        oor_reg         <= sq2_ctl.oor;
    end

    assign done               = done_reg;
    assign coefficient        = coefficient_reg;
    assign index_out_of_range = oor_reg;

    // Every accepted transaction comes out after the fixed pipeline latency.
    a_latency_out : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction did not complete after the pipeline latency");

    // No result is produced without a matching transaction accepted earlier.
    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted transaction");

    // Out-of-range indices always give a zero coefficient.
    a_oor_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_out_of_range) |-> (coefficient == 16'd0))
        else $error("out-of-range transaction returned a nonzero coefficient");

endmodule

// ===== tb/sv/window_coefficient_generator_top_test.sv =====
// Self-checking testbench of the window coefficient generator top level.
`timescale 1ns / 100ps

module window_coefficient_generator_top_test;

    localparam int LATENCY = 129;
    localparam int MAX_LEN = 4096;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned PI_FIX = 64'd3373259426;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] coef;
        logic        oor;
    } coef_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [11:0] sample_index;
    logic        done;
    logic [15:0] coefficient;
    logic        index_out_of_range;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // The testbench's own copy of the two registers.
    logic [12:0] length_reg;
    logic [2:0]  shape_reg;

    logic [11:0]  index_queue[$];
    coef_result_t coef_expected[$];
    int           mismatch_count;
    int           cycle_count;
    int           burst_left;
    int           gap_left;
    bit           hold_sender;

    window_coefficient_generator_top u_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .sample_index       (sample_index),
        .done               (done),
        .coefficient        (coefficient),
        .index_out_of_range (index_out_of_range),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Sine of pi*q/2^32 in Q30 by a fixed-point Taylor series in Horner form.
    function automatic longint unsigned sine_q30(longint unsigned q);
        longint unsigned divisors[5];
        longint unsigned t;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned s;
        divisors = '{110, 72, 42, 20, 6};
        t = (q * PI_FIX) >> 32;
        t2 = (t * t) >> 30;
        r = ONE_Q30;
        for (int k = 0; k < 5; k++)
            r = ONE_Q30 - (((t2 * r) >> 30) / divisors[k]);
        s = (t * r) >> 30;
        return (s > ONE_Q30) ? ONE_Q30 : s;
    endfunction

    // Expected coefficient transaction for one sample index.
    function automatic coef_result_t window_value(logic [11:0] idx);
        coef_result_t res;
        longint unsigned i;
        longint unsigned n;
        longint unsigned v;
        longint unsigned p;
        longint unsigned q;
        longint unsigned h;
        longint unsigned root;
        longint unsigned half;
        longint unsigned c;
        bit sat;
        i = 64'(idx);
        n = 64'(length_reg);
        v = 0;
        sat = 0;
        if (n > MAX_LEN)
            n = MAX_LEN;
        res.oor = 1'b0;
        if (i >= n)
        begin
            res.coef = '0;
            res.oor = 1'b1;
            return res;
        end
        if (shape_reg <= wcg_pkg::SHAPE_QUAD_ROOT)
        begin
            if (n < 2)
                q = 64'd1 << 31;
            else
            begin
                p = (i << 32) / (n - 1);
                q = (p <= (64'd1 << 31)) ? p : ((64'd1 << 32) - p);
            end
            h = sine_q30(q);
            h = (h * h) >> 30;
            root = isqrt(h << 30);
            case (shape_reg)
                wcg_pkg::SHAPE_HANN:      v = h;
                wcg_pkg::SHAPE_HALF_ROOT: v = root >> 1;
                wcg_pkg::SHAPE_ROOT:      v = root;
                default:                  v = isqrt(root << 30);
            endcase
        end
        else if (shape_reg == wcg_pkg::SHAPE_TRI)
        begin
            half = n >> 1;
            if (half == 0)
                sat = 1;
            else if (i < half)
                v = (i << 30) / half;
            else
                v = ((n - i) << 30) / half;
        end
        c = (v + (64'd1 << 14)) >> 15;
        res.coef = (sat || c > 65535) ? 16'hFFFF : c[15:0];
        return res;
    endfunction

    // Register write over the APB port: setup cycle, then access cycle.
    task automatic write_reg(logic addr_sel, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_sel == wcg_pkg::REG_LENGTH)
            length_reg = value[12:0];
        else
            shape_reg = value[2:0];
    endtask

    // Wait until every queued index is sent and every expected result has come back.
    task automatic drain_pipeline();
        wait (index_queue.size() == 0 && !start);
        wait (coef_expected.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic set_window(logic [12:0] len, logic [2:0] shape);
        drain_pipeline();
        write_reg(wcg_pkg::REG_LENGTH, {19'd0, len});
        write_reg(wcg_pkg::REG_SHAPE, {29'd0, shape});
    endtask

    // Driver: bursts of back-to-back transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            sample_index <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            if (start && !busy)
                coef_expected.push_back(window_value(sample_index));
            if (gap_left > 0 || hold_sender || index_queue.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                if (start && !busy)
                    start <= 1'b0;
            end
            else if (!(start && busy))
            begin
                start        <= 1'b1;
                sample_index <= index_queue.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (coef_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected transaction: coefficient %0d flag %0b",
                             coefficient, index_out_of_range);
            end
            else
            begin
                coef_result_t exp_res;
                exp_res = coef_expected.pop_front();
                if (coefficient !== exp_res.coef || index_out_of_range !== exp_res.oor)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %0d/%0b, got %0d/%0b (N=%0d shape=%0d)",
                                 exp_res.coef, exp_res.oor, coefficient,
                                 index_out_of_range, length_reg, shape_reg);
                end
            end
        end
    end

    // Watchdog on the total run time.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_random(int count, logic [12:0] len);
        int top;
        top = (len == 0) ? 15 : ((len > MAX_LEN) ? MAX_LEN - 1 : len + 3);
        if (top > 4095)
            top = 4095;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                index_queue.push_back(12'($urandom_range(0, 4095)));
            else
                index_queue.push_back(12'($urandom_range(0, top)));
        end
    endtask

    initial
    begin
        logic [12:0] len;
        logic [2:0]  shape;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_sender = 0;
        length_reg = wcg_pkg::LENGTH_RESET;
        shape_reg = wcg_pkg::SHAPE_HANN;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: ends, center, out of range.
        index_queue.push_back(12'd0);
        index_queue.push_back(12'd511);
        index_queue.push_back(12'd512);
        index_queue.push_back(12'd1023);
        index_queue.push_back(12'd1024);
        index_queue.push_back(12'd4095);
        index_queue.push_back(12'hAAA);
        index_queue.push_back(12'h555);

        // Every shape at a short odd length, including the triangle overshoot.
        for (int s = 0; s <= 7; s++)
        begin
            set_window(13'd5, s[2:0]);
            for (int k = 0; k < 6; k++)
                index_queue.push_back(k[11:0]);
        end
        // Degenerate lengths: one point, zero points, beyond the maximum.
        set_window(13'd1, wcg_pkg::SHAPE_TRI);
        index_queue.push_back(12'd0);
        index_queue.push_back(12'd1);
        set_window(13'd1, wcg_pkg::SHAPE_ROOT);
        index_queue.push_back(12'd0);
        set_window(13'd0, wcg_pkg::SHAPE_HANN);
        index_queue.push_back(12'd0);
        set_window(13'h1FFF, wcg_pkg::SHAPE_QUAD_ROOT);
        index_queue.push_back(12'd4095);
        index_queue.push_back(12'd2048);

        // Random phases, each with its own length and shape.
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: len = 13'd2;
                1: len = 13'd4096;
                2: len = 13'd3;
                default: len = ($urandom_range(0, 3) == 0)
                                ? 13'($urandom_range(0, 8191))
                                : 13'($urandom_range(2, 64));
            endcase
            shape = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            set_window(len, shape);
            queue_random(38, len);
            if (ph == 6)
            begin
                // Hold the sender until every transaction in flight has come back.
                wait (index_queue.size() == 20);
                hold_sender = 1;
                wait (coef_expected.size() == 0 && !start);
                hold_sender = 0;
            end
        end

        drain_pipeline();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
